// ----- rtl/core/lts_pkg.sv -----
// lts_pkg: shared types and constants for the lru tag store
// request/response words, scan and update control structs, opcodes, fsm states
// no dependencies
package lts_pkg;

   // fixed field widths of the request and response words
   localparam int KEY_FW  = 64;
   localparam int SLOT_FW = 3;
   localparam int OCC_FW  = 4;
   localparam int CAP_FW  = 4;

   // opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   // capacity register value after reset
   localparam logic [CAP_FW-1:0] CAPACITY_RESET = 4'd5;

   // request word
   typedef struct packed {
      logic              opcode;
      logic [KEY_FW-1:0] lookup_key;
   } lts_req_type;

   // response word
   typedef struct packed {
      logic               hit;
      logic [SLOT_FW-1:0] slot;
      logic               evicted;
      logic [KEY_FW-1:0]  evicted_key;
      logic [OCC_FW-1:0]  occupancy;
   } lts_rsp_type;

   // control flags that walk down the cell chain with a request
   typedef struct packed {
      logic vld;
      logic opcode;
      logic match_en;
      logic hit_found;
      logic old_found;
      logic free_found;
   } lts_scan_type;

   // update command broadcast to all cells when a scan completes
   typedef struct packed {
      logic en;
      logic store;
   } lts_upd_type;

   // top level control states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } lts_state_type;

endpackage

// ----- rtl/core/lts_cell.sv -----
// lts_cell: one directory entry (key, valid, recency rank) plus one scan stage
// folds its entry into the best-match / oldest / first-free search and passes it on
// depends on lts_pkg
module lts_cell #(
   parameter int MAX_ENTRIES = 8,
   parameter int KEY_BITS    = 64,
   parameter int SLOT_W      = 3,
   parameter int CELL_IDX    = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   // scan from the previous cell
   input  lts_pkg::lts_scan_type    up_scan,
   input  logic [KEY_BITS-1:0]      up_key,
   input  logic [SLOT_W-1:0]        up_hrank,
   input  logic [SLOT_W-1:0]        up_hslot,
   input  logic [SLOT_W-1:0]        up_orank,
   input  logic [SLOT_W-1:0]        up_oslot,
   input  logic [KEY_BITS-1:0]      up_okey,
   input  logic [SLOT_W-1:0]        up_fslot,
   // scan to the next cell
   output lts_pkg::lts_scan_type    dn_scan,
   output logic [KEY_BITS-1:0]      dn_key,
   output logic [SLOT_W-1:0]        dn_hrank,
   output logic [SLOT_W-1:0]        dn_hslot,
   output logic [SLOT_W-1:0]        dn_orank,
   output logic [SLOT_W-1:0]        dn_oslot,
   output logic [KEY_BITS-1:0]      dn_okey,
   output logic [SLOT_W-1:0]        dn_fslot,
   // update broadcast
   input  lts_pkg::lts_upd_type     upd,
   input  logic [SLOT_W-1:0]        upd_slot,
   input  logic [SLOT_W-1:0]        upd_rank,
   input  logic [KEY_BITS-1:0]      upd_key,
   // entry status
   output logic                     entry_valid
);
   import lts_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(CELL_IDX);
   localparam logic [SLOT_W-1:0] RANK_TOP = SLOT_W'(MAX_ENTRIES - 1);

   // entry state
   logic [KEY_BITS-1:0] ekey_ff, ekey_in;
   logic                valid_ff, valid_in;
   logic [SLOT_W-1:0]   rank_ff, rank_in;

   // scan stage registers
   lts_scan_type        scan_ff, scan_in;
   logic [KEY_BITS-1:0] skey_ff, skey_in;
   logic [SLOT_W-1:0]   hrank_ff, hrank_in;
   logic [SLOT_W-1:0]   hslot_ff, hslot_in;
   logic [SLOT_W-1:0]   orank_ff, orank_in;
   logic [SLOT_W-1:0]   oslot_ff, oslot_in;
   logic [KEY_BITS-1:0] okey_ff, okey_in;
   logic [SLOT_W-1:0]   fslot_ff, fslot_in;

   logic hit_take, old_take, free_take, is_tgt;

   // local decisions: strict compares keep the lowest slot on ties
   assign hit_take  = up_scan.match_en && valid_ff && (ekey_ff == up_key) &&
                      (!up_scan.hit_found || (rank_ff < up_hrank));
   assign old_take  = valid_ff && (!up_scan.old_found || (rank_ff > up_orank));
   assign free_take = !valid_ff && !up_scan.free_found;
   assign is_tgt    = (upd_slot == MY_SLOT);

   // fold this entry into the running search
   always_comb begin
      scan_in  = up_scan;
      skey_in  = up_key;
      hrank_in = up_hrank;
      hslot_in = up_hslot;
      orank_in = up_orank;
      oslot_in = up_oslot;
      okey_in  = up_okey;
      fslot_in = up_fslot;
      if (hit_take) begin
         scan_in.hit_found = 1'b1;
         hrank_in          = rank_ff;
         hslot_in          = MY_SLOT;
      end
      if (old_take) begin
         scan_in.old_found = 1'b1;
         orank_in          = rank_ff;
         oslot_in          = MY_SLOT;
         okey_in           = ekey_ff;
      end
      if (free_take) begin
         scan_in.free_found = 1'b1;
         fslot_in           = MY_SLOT;
      end
   end

   // entry update on broadcast
   always_comb begin
      ekey_in  = ekey_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.en) begin
         if (upd.store) begin
            if (is_tgt) begin
               ekey_in  = upd_key;
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff < RANK_TOP)) begin
               rank_in = rank_ff + 1'b1;
            end
         end else begin
            if (is_tgt) begin
               rank_in = '0;
            end else if (valid_ff && (rank_ff < upd_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         scan_ff  <= scan_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ekey_ff  <= ekey_in;
      skey_ff  <= skey_in;
      hrank_ff <= hrank_in;
      hslot_ff <= hslot_in;
      orank_ff <= orank_in;
      oslot_ff <= oslot_in;
      okey_ff  <= okey_in;
      fslot_ff <= fslot_in;
   end

   assign dn_scan     = scan_ff;
   assign dn_key      = skey_ff;
   assign dn_hrank    = hrank_ff;
   assign dn_hslot    = hslot_ff;
   assign dn_orank    = orank_ff;
   assign dn_oslot    = oslot_ff;
   assign dn_okey     = okey_ff;
   assign dn_fslot    = fslot_ff;
   assign entry_valid = valid_ff;

endmodule

// ----- rtl/core/lru_tag_store_unit.sv -----
// lru_tag_store_unit: fully associative lru directory built as a chain of entry cells
// depends on lts_pkg and lts_cell
//
// A command word is taken when start is high and busy is low. The key then walks
// the chain of MAX_ENTRIES entry cells, one cell per cycle, collecting the most
// recent matching entry, the least recent entry and the first free slot. When it
// leaves the last cell the directory is updated and the response word registered
// alongside it, shown on rsp_strobe for a single cycle. busy drops with the strobe,
// so a new command can be taken once the response appears, not before. The
// response cannot be held off; the receiver must take it when rsp_strobe is high.
// Capacity is written through the csr port while busy is low; values of 0 act as 1
// and values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_tag_store_unit #(
   parameter int MAX_ENTRIES = 8,
   parameter int KEY_BITS    = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // command channel
   input  logic                         start,
   output logic                         busy,
   input  lts_pkg::lts_req_type         req_data,
   // response channel
   output logic                         rsp_strobe,
   output lts_pkg::lts_rsp_type         rsp_data,
   // capacity register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lts_pkg::CAP_FW-1:0]   csr_wdata
);
   import lts_pkg::*;

   localparam int SLOT_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_FW) ? CNT_W : CAP_FW;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);
   localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

   // control and status registers
   lts_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAP_FW-1:0]   cap_ff, cap_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   lts_rsp_type         rsp_data_ff, rsp_data_in;

   // chain stage wires: index 0 feeds the first cell, index MAX_ENTRIES is the tail
   lts_scan_type        st_scan  [MAX_ENTRIES+1];
   logic [KEY_BITS-1:0] st_key   [MAX_ENTRIES+1];
   logic [SLOT_W-1:0]   st_hrank [MAX_ENTRIES+1];
   logic [SLOT_W-1:0]   st_hslot [MAX_ENTRIES+1];
   logic [SLOT_W-1:0]   st_orank [MAX_ENTRIES+1];
   logic [SLOT_W-1:0]   st_oslot [MAX_ENTRIES+1];
   logic [KEY_BITS-1:0] st_okey  [MAX_ENTRIES+1];
   logic [SLOT_W-1:0]   st_fslot [MAX_ENTRIES+1];

   logic [MAX_ENTRIES-1:0] valid_vec;
   logic [MAX_ENTRIES-1:0] chain_vld;

   logic                req_accept;
   logic [KEY_BITS-1:0] req_key;
   lts_scan_type        inj_scan;

   lts_upd_type         upd;
   logic [SLOT_W-1:0]   upd_slot, upd_rank, store_slot;
   logic [CMP_W-1:0]    cap_ext, eff_cap;
   logic                room;

   // handshakes
   assign busy       = (state_ff == ST_SCAN);
   assign req_accept = start && !busy;
   assign csr_ready  = !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // request injection into the first cell
   assign req_key = req_data.lookup_key[KEY_BITS-1:0];

   always_comb begin
      inj_scan          = '0;
      inj_scan.vld      = req_accept;
      inj_scan.opcode   = req_data.opcode;
      inj_scan.match_en = (req_data.opcode == OP_LOOKUP) && (|req_key);
   end

   assign st_scan[0]  = inj_scan;
   assign st_key[0]   = req_key;
   assign st_hrank[0] = '0;
   assign st_hslot[0] = '0;
   assign st_orank[0] = '0;
   assign st_oslot[0] = '0;
   assign st_okey[0]  = '0;
   assign st_fslot[0] = '0;

   // chain of entry cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lts_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .KEY_BITS    (KEY_BITS),
         .SLOT_W      (SLOT_W),
         .CELL_IDX    (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_scan     (st_scan[i]),
         .up_key      (st_key[i]),
         .up_hrank    (st_hrank[i]),
         .up_hslot    (st_hslot[i]),
         .up_orank    (st_orank[i]),
         .up_oslot    (st_oslot[i]),
         .up_okey     (st_okey[i]),
         .up_fslot    (st_fslot[i]),
         .dn_scan     (st_scan[i+1]),
         .dn_key      (st_key[i+1]),
         .dn_hrank    (st_hrank[i+1]),
         .dn_hslot    (st_hslot[i+1]),
         .dn_orank    (st_orank[i+1]),
         .dn_oslot    (st_oslot[i+1]),
         .dn_okey     (st_okey[i+1]),
         .dn_fslot    (st_fslot[i+1]),
         .upd         (upd),
         .upd_slot    (upd_slot),
         .upd_rank    (upd_rank),
         .upd_key     (st_key[MAX_ENTRIES]),
         .entry_valid (valid_vec[i])
      );
      assign chain_vld[i] = st_scan[i+1].vld;
   end

   // effective capacity, clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = ONE_CMP;
      end else if (cap_ext > MAX_CMP) begin
         eff_cap = MAX_CMP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign room = (CMP_W'(count_ff) < eff_cap);

   // capacity register write
   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end
   end

   // sequencing and resolution at the chain tail
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      upd           = '0;
      upd_slot      = '0;
      upd_rank      = '0;
      store_slot    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st_scan[MAX_ENTRIES].vld) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               if (st_scan[MAX_ENTRIES].opcode == OP_LOOKUP) begin
                  // hit: promote the matched entry
                  if (st_scan[MAX_ENTRIES].hit_found) begin
                     rsp_data_in.hit  = 1'b1;
                     rsp_data_in.slot = SLOT_FW'(st_hslot[MAX_ENTRIES]);
                     upd.en           = 1'b1;
                     upd_slot         = st_hslot[MAX_ENTRIES];
                     upd_rank         = st_hrank[MAX_ENTRIES];
                  end
               end else begin
                  // store: free slot while below capacity, else evict the oldest, else slot 0
                  if (room && st_scan[MAX_ENTRIES].free_found) begin
                     store_slot = st_fslot[MAX_ENTRIES];
                     count_in   = CNT_W'(count_ff + 1'b1);
                  end else if (st_scan[MAX_ENTRIES].old_found) begin
                     store_slot              = st_oslot[MAX_ENTRIES];
                     rsp_data_in.evicted     = 1'b1;
                     rsp_data_in.evicted_key = KEY_FW'(st_okey[MAX_ENTRIES]);
                  end else begin
                     store_slot = '0;
                     count_in   = CNT_W'(1);
                  end
                  upd.en           = 1'b1;
                  upd.store        = 1'b1;
                  upd_slot         = store_slot;
                  rsp_data_in.slot = SLOT_FW'(store_slot);
               end
               rsp_data_in.occupancy = OCC_FW'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cap_ff        <= CAPACITY_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // at most one request in flight along the chain
   a_chain_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld))
      else $error("more than one request in the cell chain");

   // a request leaving the chain produces a response strobe next cycle
   a_tail_rsp: assert property (@(posedge clock) disable iff (reset)
      chain_vld[MAX_ENTRIES-1] |=> rsp_strobe_ff)
      else $error("chain tail did not produce a response");

   // an accepted command keeps the unit busy for the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy)
      else $error("busy not raised after accepting a command");

   // occupancy count tracks the number of valid entries
   a_occ_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("occupancy count differs from valid entry count");

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for lru_tag_store_unit, the lru tag directory
// directed table then random bursts of lookup/store words, checked against a local predictor
// depends on lts_pkg and lru_tag_store_unit
`timescale 1ns / 100ps

module tb;
   import lts_pkg::*;

   localparam int N_ENT       = 8;
   localparam int RSP_LAT     = N_ENT + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_PHASES    = 10;
   localparam int PHASE_WORDS = 50;
   localparam int POOL_SZ     = 6;

   typedef enum logic [1:0] {
      ROW_CMD,
      ROW_CHK,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [CAP_FW-1:0]   cap;
      lts_req_type         word;
      lts_rsp_type         lit;
   } dir_row_type;

   // dut ports; the driven inputs are known from time zero
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               start      = 1'b0;
   logic               busy;
   lts_req_type        req_data   = '0;
   logic               rsp_strobe;
   lts_rsp_type        rsp_data;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [CAP_FW-1:0]  csr_wdata  = '0;

   // predicted directory contents
   logic [KEY_FW-1:0]  dir_key [N_ENT];
   bit                 dir_vld [N_ENT];
   int unsigned        dir_rank [N_ENT];
   int                 dir_cnt;
   logic [CAP_FW-1:0]  cap_reg;

   // expected response words, oldest first
   lts_rsp_type        rsp_pending [$];

   int err_cnt   = 0;
   int n_sent    = 0;
   int n_checked = 0;
   int n_csr     = 0;
   int n_hits    = 0;
   int n_evicts  = 0;
   int cyc       = 0;

   logic [KEY_FW-1:0]  key_pool [POOL_SZ];
   dir_row_type        dir_tab [$];

   lru_tag_store_unit #(
      .MAX_ENTRIES(N_ENT),
      .KEY_BITS(KEY_FW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cyc < CYCLE_LIMIT) begin
         @(posedge clock);
         cyc++;
      end
      $display("timeout after %0d cycles", cyc);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // directory state after reset
   function automatic void clear_directory();
      int i;
      for (i = 0; i < N_ENT; i++) begin
         dir_key[i]  = '0;
         dir_vld[i]  = 1'b0;
         dir_rank[i] = 0;
      end
      dir_cnt = 0;
      cap_reg = CAPACITY_RESET;
   endfunction

   // work out the response to one command word and advance the directory
   function automatic lts_rsp_type predict_word(input lts_req_type w);
      lts_rsp_type r;
      int i;
      int found;
      int tgt;
      int cap_eff;
      int unsigned rk;
      r = '0;
      if (w.opcode == OP_LOOKUP) begin
         // most recent valid copy of the key; key zero never matches
         found = N_ENT;
         if (w.lookup_key != '0) begin
            for (i = 0; i < N_ENT; i++) begin
               if (dir_vld[i] && dir_key[i] == w.lookup_key &&
                   (found == N_ENT || dir_rank[i] < dir_rank[found]))
                  found = i;
            end
         end
         if (found < N_ENT) begin
            rk = dir_rank[found];
            for (i = 0; i < N_ENT; i++) begin
               if (dir_vld[i] && dir_rank[i] < rk)
                  dir_rank[i]++;
            end
            dir_rank[found] = 0;
            r.hit  = 1'b1;
            r.slot = found[SLOT_FW-1:0];
         end
      end else begin
         cap_eff = (cap_reg == 0) ? 1 : (cap_reg > N_ENT) ? N_ENT : int'(cap_reg);
         tgt = N_ENT;
         // first free slot while below capacity
         if (dir_cnt < cap_eff) begin
            for (i = 0; i < N_ENT; i++) begin
               if (!dir_vld[i] && tgt == N_ENT)
                  tgt = i;
            end
            if (tgt < N_ENT)
               dir_cnt++;
         end
         // otherwise evict the least recent entry
         if (tgt == N_ENT) begin
            for (i = 0; i < N_ENT; i++) begin
               if (dir_vld[i] && (tgt == N_ENT || dir_rank[i] > dir_rank[tgt]))
                  tgt = i;
            end
            if (tgt < N_ENT) begin
               r.evicted     = 1'b1;
               r.evicted_key = dir_key[tgt];
               dir_vld[tgt]  = 1'b0;
            end else begin
               tgt     = 0;
               dir_cnt = 1;
            end
         end
         // age everyone, then insert as newest
         for (i = 0; i < N_ENT; i++) begin
            if (dir_vld[i] && dir_rank[i] < N_ENT - 1)
               dir_rank[i]++;
         end
         dir_key[tgt]  = w.lookup_key;
         dir_vld[tgt]  = 1'b1;
         dir_rank[tgt] = 0;
         r.slot = tgt[SLOT_FW-1:0];
      end
      r.occupancy = dir_cnt[OCC_FW-1:0];
      return r;
   endfunction

   function automatic lts_req_type mk_req(input logic op, input logic [KEY_FW-1:0] key);
      lts_req_type w;
      w.opcode     = op;
      w.lookup_key = key;
      return w;
   endfunction

   function automatic lts_rsp_type mk_rsp(input logic h, input int s, input logic ev,
                                          input logic [KEY_FW-1:0] ek, input int occ);
      lts_rsp_type r;
      r.hit         = h;
      r.slot        = s[SLOT_FW-1:0];
      r.evicted     = ev;
      r.evicted_key = ek;
      r.occupancy   = occ[OCC_FW-1:0];
      return r;
   endfunction

   // table rows: predicted command, command with literal response, capacity write
   function automatic void cmd_row(input logic op, input logic [KEY_FW-1:0] key);
      dir_row_type d;
      d.kind = ROW_CMD;
      d.cap  = '0;
      d.word = mk_req(op, key);
      d.lit  = '0;
      dir_tab.push_back(d);
   endfunction

   function automatic void chk_row(input logic op, input logic [KEY_FW-1:0] key,
                                   input lts_rsp_type lit);
      dir_row_type d;
      d.kind = ROW_CHK;
      d.cap  = '0;
      d.word = mk_req(op, key);
      d.lit  = lit;
      dir_tab.push_back(d);
   endfunction

   function automatic void csr_row(input logic [CAP_FW-1:0] v);
      dir_row_type d;
      d.kind = ROW_CSR;
      d.cap  = v;
      d.word = '0;
      d.lit  = '0;
      dir_tab.push_back(d);
   endfunction

   // present one command word and hold it until taken
   task automatic drive_word(input lts_req_type w, input bit use_lit, input lts_rsp_type lit);
      lts_rsp_type p;
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      p = predict_word(w);
      rsp_pending.push_back(use_lit ? lit : p);
      n_sent++;
   endtask

   // nothing outstanding and the unit not busy
   task automatic wait_idle();
      while (rsp_pending.size() != 0 || busy)
         @(posedge clock);
   endtask

   // capacity write, only while idle
   task automatic write_capacity(input logic [CAP_FW-1:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cap_reg = v;
      n_csr++;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_FW-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // mostly pool keys so lookups hit and duplicates pile up, plus some noise
   function automatic lts_req_type rand_word();
      int sel;
      logic op;
      logic [KEY_FW-1:0] key;
      sel = $urandom_range(0, 99);
      op  = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_LOOKUP;
      if (sel < 80)
         key = key_pool[$urandom_range(0, POOL_SZ - 1)];
      else if (sel < 90)
         key = rand_key();
      else if (sel < 95)
         key = '0;
      else if (sel < 98)
         key = {KEY_FW{1'b1}};
      else
         key = 64'h1 << $urandom_range(0, KEY_FW - 1);
      return mk_req(op, key);
   endfunction

   // one random phase: bursts of command words with random gaps
   task automatic run_phase(input int n_words);
      int i;
      int b;
      int burst;
      for (i = 0; i < POOL_SZ; i++)
         key_pool[i] = (i == 0) ? KEY_FW'($urandom_range(1, 15)) : rand_key();
      i = 0;
      while (i < n_words) begin
         burst = $urandom_range(1, 8);
         for (b = 0; b < burst && i < n_words; b++) begin
            drive_word(rand_word(), 1'b0, '0);
            i++;
         end
         // gap after most bursts, back to back otherwise
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14))
               @(posedge clock);
         end
      end
   endtask

   // response checker
   always @(posedge clock) begin
      lts_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (rsp_pending.size() == 0) begin
            $error("response word with nothing expected: %h", rsp_data);
            err_cnt++;
         end else begin
            e = rsp_pending.pop_front();
            n_checked++;
            if (rsp_data.hit)
               n_hits++;
            if (rsp_data.evicted)
               n_evicts++;
            if (rsp_data.hit !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_data.hit);
               err_cnt++;
            end
            if (rsp_data.slot !== e.slot) begin
               $error("slot: expected %0d, got %0d", e.slot, rsp_data.slot);
               err_cnt++;
            end
            if (rsp_data.evicted !== e.evicted) begin
               $error("evicted: expected %0d, got %0d", e.evicted, rsp_data.evicted);
               err_cnt++;
            end
            if (rsp_data.evicted_key !== e.evicted_key) begin
               $error("evicted_key: expected %h, got %h", e.evicted_key, rsp_data.evicted_key);
               err_cnt++;
            end
            if (rsp_data.occupancy !== e.occupancy) begin
               $error("occupancy: expected %0d, got %0d", e.occupancy, rsp_data.occupancy);
               err_cnt++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [CAP_FW-1:0] phase_cap [N_PHASES];
      int k;
      int ph;
      clear_directory();

      // directed table, capacity at its reset value of 5
      chk_row(OP_LOOKUP, 64'h0, mk_rsp(0, 0, 0, 64'h0, 0));
      chk_row(OP_LOOKUP, {KEY_FW{1'b1}}, mk_rsp(0, 0, 0, 64'h0, 0));
      chk_row(OP_STORE, {KEY_FW{1'b1}}, mk_rsp(0, 0, 0, 64'h0, 1));
      chk_row(OP_LOOKUP, {KEY_FW{1'b1}}, mk_rsp(1, 0, 0, 64'h0, 1));
      chk_row(OP_STORE, 64'h1, mk_rsp(0, 1, 0, 64'h0, 2));
      // duplicate store, lookup must find the newer copy
      chk_row(OP_STORE, 64'h1, mk_rsp(0, 2, 0, 64'h0, 3));
      chk_row(OP_LOOKUP, 64'h1, mk_rsp(1, 2, 0, 64'h0, 3));
      // empty key: stored like any other, but never found
      chk_row(OP_STORE, 64'h0, mk_rsp(0, 3, 0, 64'h0, 4));
      chk_row(OP_LOOKUP, 64'h0, mk_rsp(0, 0, 0, 64'h0, 4));
      cmd_row(OP_STORE, 64'h8000_0000_0000_0000);
      // full at capacity 5, evicts from here on
      cmd_row(OP_STORE, 64'h5555_5555_5555_5555);
      cmd_row(OP_LOOKUP, 64'h8000_0000_0000_0000);
      // capacity 0 acts as 1, below occupancy
      csr_row(4'd0);
      cmd_row(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
      cmd_row(OP_LOOKUP, 64'h1);
      // capacity above the entry count acts as 8
      csr_row(4'd15);
      cmd_row(OP_STORE, 64'h0123_4567_89AB_CDEF);
      cmd_row(OP_STORE, 64'hFEDC_BA98_7654_3210);
      cmd_row(OP_STORE, 64'h0F0F_0F0F_0F0F_0F0F);
      cmd_row(OP_STORE, 64'hF0F0_F0F0_F0F0_F0F0);
      cmd_row(OP_LOOKUP, 64'h5555_5555_5555_5555);
      csr_row(4'd8);
      cmd_row(OP_STORE, 64'h2);
      csr_row(4'd1);
      cmd_row(OP_STORE, 64'h3);
      cmd_row(OP_LOOKUP, 64'h3);
      cmd_row(OP_LOOKUP, 64'hFEDC_BA98_7654_3210);

      // hold reset, then release it
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      for (k = 0; k < dir_tab.size(); k++) begin
         if (dir_tab[k].kind == ROW_CSR) begin
            start <= 1'b0;
            write_capacity(dir_tab[k].cap);
         end else begin
            drive_word(dir_tab[k].word, dir_tab[k].kind == ROW_CHK, dir_tab[k].lit);
         end
      end
      start <= 1'b0;

      // random phases, extremes of capacity first
      phase_cap[0] = 4'd8;
      phase_cap[1] = 4'd1;
      phase_cap[2] = 4'd0;
      phase_cap[3] = 4'd15;
      phase_cap[4] = 4'd3;
      phase_cap[5] = 4'd2;
      for (ph = 6; ph < N_PHASES; ph++)
         phase_cap[ph] = CAP_FW'($urandom_range(0, 15));
      for (ph = 0; ph < N_PHASES; ph++) begin
         @(posedge clock);
         write_capacity(phase_cap[ph]);
         run_phase(PHASE_WORDS);
         start <= 1'b0;
      end

      // drain, then make sure nothing else shows up
      @(posedge clock);
      wait_idle();
      repeat (RSP_LAT + 2)
         @(posedge clock);

      $display("sent %0d command words, checked %0d responses (%0d hits, %0d evictions)",
               n_sent, n_checked, n_hits, n_evicts);
      $display("capacity written %0d times, %0d cycles, %0d mismatches",
               n_csr, cyc, err_cnt);
      if (err_cnt == 0 && rsp_pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (rsp_pending.size() != 0)
            $error("%0d expected responses never arrived", rsp_pending.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
